// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a consequence in the same cycle as its cause
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check a consequence in the cycle after its cause
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/hts_pkg.sv
package hts_pkg;

    // Field widths
    localparam int TIME_W     = 48;
    localparam int POS_W      = 48;
    localparam int VEL_W      = 32;
    localparam int MAT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Datapath widths
    localparam int FRAC_W    = 16;
    localparam int U_W       = FRAC_W + 1;
    localparam int BAS_W     = 20;
    localparam int DIV_STEPS = FRAC_W;
    localparam int MA_W      = 52;
    localparam int MB_W      = 49;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int ACC_W     = 104;

    // Multiplier digit width default
    localparam int MUL_DIGIT_W = 8;

    // Input opcodes
    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_EVAL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 3'd5;

    // Reset values of the frame matrix rows (identity)
    localparam logic [CFG_DATA_W-1:0] ROW0_RST = 48'h0000_0000_4000;
    localparam logic [CFG_DATA_W-1:0] ROW1_RST = 48'h0000_4000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW2_RST = 48'h4000_0000_0000;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ZERO,
        OP_COPY_OLD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIX,
        OP_MUL_UU,
        OP_MUL_U2U,
        OP_BASIS,
        OP_MUL_H00P,
        OP_MUL_H01P,
        OP_MUL_H10V,
        OP_MUL_H11V,
        OP_MUL_HVH,
        OP_LOCAL,
        OP_ORG,
        OP_MUL_ML,
        OP_WORLD,
        OP_PUBLISH
    } op_t;

    // Controller to datapath
    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic [1:0] col;
        logic       exec;
        logic       take;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mul_done;
        logic cnt_zero;
        logic use_old;
    } stat_t;

endpackage

// File: rtl/core/hts_item_if.sv
interface hts_item_if import hts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [TIME_W-1:0]       sample_time;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic [TIME_W-1:0]       query_time;

    modport source (
        output valid, opcode, sample_time, pos_x, pos_y, pos_z,
        output vel_x, vel_y, vel_z, query_time,
        input  ready
    );
    modport sink (
        input  valid, opcode, sample_time, pos_x, pos_y, pos_z,
        input  vel_x, vel_y, vel_z, query_time,
        output ready
    );
endinterface

// File: rtl/core/hts_result_if.sv
interface hts_result_if import hts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] world_x;
    logic signed [POS_W-1:0] world_y;
    logic signed [POS_W-1:0] world_z;

    modport source (output valid, world_x, world_y, world_z, input ready);
    modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

// File: rtl/core/hts_cfg_if.sv
interface hts_cfg_if import hts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/hts_mul.sv
module hts_mul import hts_pkg::*; #(
    parameter int DIGIT_W = MUL_DIGIT_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MA_W-1:0]   a,
    input  logic signed [MB_W-1:0]   b,
    output logic signed [PROD_W-1:0] p,
    output logic                     done
);

    localparam int STEPS  = (MB_W + DIGIT_W - 1) / DIGIT_W;
    localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int BSH_W  = STEPS * DIGIT_W;

    logic [MA_W-1:0]   mag_a;
    logic [MB_W-1:0]   mag_b;
    logic [PROD_W-1:0] part;

    logic [PROD_W-1:0]        a_sh_reg;
    logic [BSH_W-1:0]         b_sh_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic                     neg_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic signed [PROD_W-1:0] p_reg;

    // Split operands into sign and magnitude, and form the partial product
    always_comb
    begin
        mag_a = a[MA_W-1] ? (~a + 1'b1) : a;
        mag_b = b[MB_W-1] ? (~b + 1'b1) : b;
        part  = PROD_W'(a_sh_reg * b_sh_reg[DIGIT_W-1:0]);
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // Accumulate one digit of b per cycle, then apply the sign
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_sh_reg <= PROD_W'(mag_a);
            b_sh_reg <= BSH_W'(mag_b);
            acc_reg  <= '0;
            neg_reg  <= a[MA_W-1] ^ b[MB_W-1];
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_reg + part;
            a_sh_reg <= a_sh_reg << DIGIT_W;
            b_sh_reg <= b_sh_reg >> DIGIT_W;
        end
        if (fin_reg)
        begin
            p_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        end
    end

    assign p    = p_reg;
    assign done = done_reg;

endmodule

// File: rtl/core/hts_datapath.sv
module hts_datapath import hts_pkg::*; #(
    parameter int DIGIT_W = MUL_DIGIT_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  logic [TIME_W-1:0]       sample_time,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic signed [VEL_W-1:0] vel_x,
    input  logic signed [VEL_W-1:0] vel_y,
    input  logic signed [VEL_W-1:0] vel_z,
    input  logic [TIME_W-1:0]       query_time,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output logic signed [POS_W-1:0] world_x,
    output logic signed [POS_W-1:0] world_y,
    output logic signed [POS_W-1:0] world_z
);

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_LOCAL = ACC_W'(64'd1 << 31);
    localparam logic signed [ACC_W-1:0] RND_WORLD = ACC_W'(64'd1 << 13);
    localparam logic [U_W-1:0]          U_ONE     = U_W'(1) << FRAC_W;
    localparam logic signed [BAS_W-1:0] BAS_ONE   = BAS_W'(1) << FRAC_W;

    function automatic logic signed [POS_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[POS_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[POS_W-1:0];
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    // Sample store and configuration
    logic [TIME_W-1:0]       older_time_reg;
    logic [TIME_W-1:0]       newer_time_reg;
    logic signed [POS_W-1:0] older_pos_reg [3];
    logic signed [POS_W-1:0] newer_pos_reg [3];
    logic signed [VEL_W-1:0] older_vel_reg [3];
    logic signed [VEL_W-1:0] newer_vel_reg [3];
    logic [1:0]              count_reg;
    logic [CFG_DATA_W-1:0]   row_reg [3];
    logic signed [POS_W-1:0] origin_reg [3];

    // Working registers
    logic [TIME_W-1:0]       query_reg;
    logic [TIME_W:0]         rem_reg;
    logic [DIV_STEPS-1:0]    quo_reg;
    logic [U_W-1:0]          u_reg;
    logic [U_W-1:0]          u2_reg;
    logic [U_W-1:0]          u3_reg;
    logic signed [BAS_W-1:0] h00_reg;
    logic signed [BAS_W-1:0] h10_reg;
    logic signed [BAS_W-1:0] h01_reg;
    logic signed [BAS_W-1:0] h11_reg;
    logic signed [MA_W-1:0]  hv_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [POS_W-1:0] local_reg [3];
    logic signed [POS_W-1:0] world_reg [3];
    logic signed [POS_W-1:0] out_reg [3];

    logic signed [POS_W-1:0] in_pos [3];
    logic signed [VEL_W-1:0] in_vel [3];
    logic [TIME_W-1:0]       span;
    logic [TIME_W+1:0]       r2;
    logic                    r2_ge;
    logic                    q_lo;
    logic                    q_hi;
    logic signed [BAS_W-1:0] su;
    logic signed [BAS_W-1:0] su2;
    logic signed [BAS_W-1:0] su3;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic                    mul_start;
    logic signed [PROD_W-1:0] prod;
    logic                    mul_done;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] local_sum;
    logic signed [ACC_W-1:0] world_sum;
    logic signed [MAT_W-1:0] m_ent;

    hts_mul #(.DIGIT_W(DIGIT_W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (prod),
        .done  (mul_done)
    );

    // Interval, divider step, basis inputs, matrix entry and rounded sums
    always_comb
    begin
        in_pos[0] = pos_x;
        in_pos[1] = pos_y;
        in_pos[2] = pos_z;
        in_vel[0] = vel_x;
        in_vel[1] = vel_y;
        in_vel[2] = vel_z;
        span      = newer_time_reg - older_time_reg;
        r2        = {rem_reg, 1'b0};
        r2_ge     = r2 >= {2'b00, span};
        q_lo      = query_reg <= older_time_reg;
        q_hi      = query_reg >= newer_time_reg;
        su        = $signed(BAS_W'(u_reg));
        su2       = $signed(BAS_W'(u2_reg));
        su3       = $signed(BAS_W'(u3_reg));
        m_ent     = row_reg[cmd.axis][{cmd.col, 4'b0000} +: MAT_W];
        prod_ext  = ACC_W'(prod);
        local_sum = (acc_reg + RND_LOCAL) >>> 32;
        world_sum = (acc_reg + RND_WORLD) >>> 14;
    end

    // Select multiplier operands
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_start = 1'b0;
        case (cmd.op)
            OP_MUL_UU:
            begin
                mul_a     = MA_W'(u_reg);
                mul_b     = MB_W'(u_reg);
                mul_start = cmd.exec;
            end
            OP_MUL_U2U:
            begin
                mul_a     = MA_W'(u2_reg);
                mul_b     = MB_W'(u_reg);
                mul_start = cmd.exec;
            end
            OP_MUL_H00P:
            begin
                mul_a     = MA_W'(h00_reg);
                mul_b     = MB_W'(older_pos_reg[cmd.axis]);
                mul_start = cmd.exec;
            end
            OP_MUL_H01P:
            begin
                mul_a     = MA_W'(h01_reg);
                mul_b     = MB_W'(newer_pos_reg[cmd.axis]);
                mul_start = cmd.exec;
            end
            OP_MUL_H10V:
            begin
                mul_a     = MA_W'(h10_reg);
                mul_b     = MB_W'(older_vel_reg[cmd.axis]);
                mul_start = cmd.exec;
            end
            OP_MUL_H11V:
            begin
                mul_a     = MA_W'(h11_reg);
                mul_b     = MB_W'(newer_vel_reg[cmd.axis]);
                mul_start = cmd.exec;
            end
            OP_MUL_HVH:
            begin
                mul_a     = hv_reg;
                mul_b     = $signed({1'b0, span});
                mul_start = cmd.exec;
            end
            OP_MUL_ML:
            begin
                mul_a     = MA_W'(m_ent);
                mul_b     = MB_W'(local_reg[cmd.col]);
                mul_start = cmd.exec;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Hold samples and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_time_reg <= '0;
            newer_time_reg <= '0;
            count_reg      <= '0;
            row_reg[0]     <= ROW0_RST;
            row_reg[1]     <= ROW1_RST;
            row_reg[2]     <= ROW2_RST;
            for (int i = 0; i < 3; i++)
            begin
                older_pos_reg[i] <= '0;
                newer_pos_reg[i] <= '0;
                older_vel_reg[i] <= '0;
                newer_vel_reg[i] <= '0;
                origin_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cmd.exec && cmd.op == OP_LOAD)
            begin
                if (count_reg == 2'd0)
                begin
                    older_time_reg <= sample_time;
                    for (int i = 0; i < 3; i++)
                    begin
                        older_pos_reg[i] <= in_pos[i];
                        older_vel_reg[i] <= in_vel[i];
                    end
                    count_reg <= 2'd1;
                end
                else
                begin
                    if (count_reg == 2'd2)
                    begin
                        older_time_reg <= newer_time_reg;
                        for (int i = 0; i < 3; i++)
                        begin
                            older_pos_reg[i] <= newer_pos_reg[i];
                            older_vel_reg[i] <= newer_vel_reg[i];
                        end
                    end
                    newer_time_reg <= sample_time;
                    for (int i = 0; i < 3; i++)
                    begin
                        newer_pos_reg[i] <= in_pos[i];
                        newer_vel_reg[i] <= in_vel[i];
                    end
                    count_reg <= 2'd2;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW0:  row_reg[0]    <= cfg_data;
                    REG_ROW1:  row_reg[1]    <= cfg_data;
                    REG_ROW2:  row_reg[2]    <= cfg_data;
                    REG_ORG_X: origin_reg[0] <= $signed(cfg_data);
                    REG_ORG_Y: origin_reg[1] <= $signed(cfg_data);
                    REG_ORG_Z: origin_reg[2] <= $signed(cfg_data);
                    default:   ;
                endcase
            end
        end
    end

    // Execute micro-operations and take multiplier results
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            query_reg <= query_time;
        end
        if (cmd.exec)
        begin
            case (cmd.op)
                OP_ZERO:
                begin
                    for (int i = 0; i < 3; i++)
                        world_reg[i] <= '0;
                end
                OP_COPY_OLD:
                begin
                    for (int i = 0; i < 3; i++)
                        local_reg[i] <= older_pos_reg[i];
                end
                OP_DIV_INIT:
                begin
                    rem_reg <= {1'b0, query_reg - older_time_reg};
                    quo_reg <= '0;
                end
                OP_DIV_STEP:
                begin
                    rem_reg <= r2_ge ? (TIME_W+1)'(r2 - {2'b00, span}) : r2[TIME_W:0];
                    quo_reg <= {quo_reg[DIV_STEPS-2:0], r2_ge};
                end
                OP_DIV_FIX:
                begin
                    u_reg <= q_lo ? '0 : (q_hi ? U_ONE : U_W'(quo_reg));
                end
                OP_BASIS:
                begin
                    h00_reg <= su3 + su3 - su2 - su2 - su2 + BAS_ONE;
                    h10_reg <= su3 - su2 - su2 + su;
                    h01_reg <= su2 + su2 + su2 - su3 - su3;
                    h11_reg <= su3 - su2;
                end
                OP_LOCAL:
                begin
                    local_reg[cmd.axis] <= sat48(local_sum);
                end
                OP_ORG:
                begin
                    acc_reg <= ACC_W'(origin_reg[cmd.axis]) <<< 14;
                end
                OP_WORLD:
                begin
                    world_reg[cmd.axis] <= sat48(world_sum);
                end
                OP_PUBLISH:
                begin
                    for (int i = 0; i < 3; i++)
                        out_reg[i] <= world_reg[i];
                end
                default: ;
            endcase
        end
        if (mul_done)
        begin
            case (cmd.op)
                OP_MUL_UU:   u2_reg  <= prod[2*FRAC_W:FRAC_W];
                OP_MUL_U2U:  u3_reg  <= prod[2*FRAC_W:FRAC_W];
                OP_MUL_H00P: acc_reg <= prod_ext <<< FRAC_W;
                OP_MUL_H01P: acc_reg <= acc_reg + (prod_ext <<< FRAC_W);
                OP_MUL_H10V: hv_reg  <= prod[MA_W-1:0];
                OP_MUL_H11V: hv_reg  <= prod[MA_W-1:0];
                OP_MUL_HVH:  acc_reg <= acc_reg + prod_ext;
                OP_MUL_ML:   acc_reg <= acc_reg + prod_ext;
                default: ;
            endcase
        end
    end

    // Status to the controller
    assign stat.mul_done = mul_done;
    assign stat.cnt_zero = count_reg == 2'd0;
    assign stat.use_old  = (count_reg == 2'd1) || !(newer_time_reg > older_time_reg);

    assign world_x = out_reg[0];
    assign world_y = out_reg[1];
    assign world_z = out_reg[2];

endmodule

// File: rtl/core/hts_ctrl.sv
module hts_ctrl import hts_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  logic  opcode,
    output logic  result_valid,
    input  logic  result_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_DIV_INIT = 6'd0;
    localparam logic [PC_W-1:0] PC_DIV_STEP = 6'd1;
    localparam logic [PC_W-1:0] PC_DIV_FIX  = 6'd2;
    localparam logic [PC_W-1:0] PC_UU       = 6'd3;
    localparam logic [PC_W-1:0] PC_U2U      = 6'd4;
    localparam logic [PC_W-1:0] PC_BASIS    = 6'd5;
    localparam logic [PC_W-1:0] PC_BLEND    = 6'd6;
    localparam logic [PC_W-1:0] PC_WORLD    = 6'd27;
    localparam logic [PC_W-1:0] PC_PUBLISH  = 6'd42;
    localparam logic [PC_W-1:0] BLEND_LEN   = 6'd7;
    localparam logic [PC_W-1:0] WORLD_LEN   = 6'd5;
    localparam int DCNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic [1:0] col;
    } uop_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    // Micro-program: divider, basis, blend per axis, frame transform per row, publish
    function automatic uop_t prog_at(input logic [PC_W-1:0] pc);
        uop_t            u;
        logic [PC_W-1:0] k;
        u.op   = OP_NONE;
        u.axis = 2'd0;
        u.col  = 2'd0;
        k      = '0;
        if (pc == PC_DIV_INIT)
            u.op = OP_DIV_INIT;
        else if (pc == PC_DIV_STEP)
            u.op = OP_DIV_STEP;
        else if (pc == PC_DIV_FIX)
            u.op = OP_DIV_FIX;
        else if (pc == PC_UU)
            u.op = OP_MUL_UU;
        else if (pc == PC_U2U)
            u.op = OP_MUL_U2U;
        else if (pc == PC_BASIS)
            u.op = OP_BASIS;
        else if (pc < PC_WORLD)
        begin
            k = pc - PC_BLEND;
            if (k >= BLEND_LEN + BLEND_LEN)
            begin
                u.axis = 2'd2;
                k      = k - BLEND_LEN - BLEND_LEN;
            end
            else if (k >= BLEND_LEN)
            begin
                u.axis = 2'd1;
                k      = k - BLEND_LEN;
            end
            case (k)
                6'd0:    u.op = OP_MUL_H00P;
                6'd1:    u.op = OP_MUL_H01P;
                6'd2:    u.op = OP_MUL_H10V;
                6'd3:    u.op = OP_MUL_HVH;
                6'd4:    u.op = OP_MUL_H11V;
                6'd5:    u.op = OP_MUL_HVH;
                default: u.op = OP_LOCAL;
            endcase
        end
        else if (pc < PC_PUBLISH)
        begin
            k = pc - PC_WORLD;
            if (k >= WORLD_LEN + WORLD_LEN)
            begin
                u.axis = 2'd2;
                k      = k - WORLD_LEN - WORLD_LEN;
            end
            else if (k >= WORLD_LEN)
            begin
                u.axis = 2'd1;
                k      = k - WORLD_LEN;
            end
            case (k)
                6'd0:    u.op = OP_ORG;
                6'd1:    u.op = OP_MUL_ML;
                6'd2:    u.op = OP_MUL_ML;
                6'd3:    u.op = OP_MUL_ML;
                default: u.op = OP_WORLD;
            endcase
            // Column only matters on the three products
            if (k >= 6'd1 && k <= 6'd3)
                u.col = 2'(k - 6'd1);
        end
        else
            u.op = OP_PUBLISH;
        return u;
    endfunction

    function automatic logic is_mul(input op_t op);
        return (op == OP_MUL_UU) || (op == OP_MUL_U2U) || (op == OP_MUL_H00P) ||
               (op == OP_MUL_H01P) || (op == OP_MUL_H10V) || (op == OP_MUL_H11V) ||
               (op == OP_MUL_HVH) || (op == OP_MUL_ML);
    endfunction

    state_t              state_reg, state_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                out_valid_reg, out_valid_next;
    uop_t                uop;
    logic                item_beat;

    // Sequence the micro-program
    always_comb
    begin
        uop            = prog_at(pc_reg);
        state_next     = state_reg;
        pc_next        = pc_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg;
        item_ready     = state_reg == ST_IDLE;
        item_beat      = item_valid && item_ready;
        cmd.op         = uop.op;
        cmd.axis       = uop.axis;
        cmd.col        = uop.col;
        cmd.exec       = 1'b0;
        cmd.take       = 1'b0;

        // Drop the result beat once taken
        if (result_valid && result_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.op = OP_NONE;
                if (item_beat)
                begin
                    cmd.take = 1'b1;
                    cmd.exec = 1'b1;
                    if (opcode == OPC_LOAD)
                        cmd.op = OP_LOAD;
                    else if (stat.cnt_zero)
                    begin
                        cmd.op     = OP_ZERO;
                        pc_next    = PC_PUBLISH;
                        state_next = ST_RUN;
                    end
                    else if (stat.use_old)
                    begin
                        cmd.op     = OP_COPY_OLD;
                        pc_next    = PC_WORLD;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        pc_next    = PC_DIV_INIT;
                        dcnt_next  = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (uop.op == OP_PUBLISH)
                begin
                    if (!out_valid_reg || result_ready)
                    begin
                        cmd.exec       = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (is_mul(uop.op))
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_WAIT;
                end
                else if (uop.op == OP_DIV_STEP)
                begin
                    cmd.exec  = 1'b1;
                    dcnt_next = dcnt_reg + 1'b1;
                    if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                        pc_next = pc_reg + 1'b1;
                end
                else
                begin
                    cmd.exec = 1'b1;
                    pc_next  = pc_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (stat.mul_done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// File: rtl/core/hermite_trajectory_sampler.sv
// Load beat: stored in the cycle it is accepted, next item taken from the cycle after.
// Evaluate beat, two samples: 16-step divider, then 29 products on one shared multiplier
// taking 8-bit digits; one sample: frame transform only; none: zero result.
// One item in flight; the result waits in an output register while new items are taken.
// rst_n (async, active low) clears the sample store, sets identity matrix and zero origin.
`include "assert_macros.svh"

module hermite_trajectory_sampler import hts_pkg::*; #(
    parameter int DIGIT_W = MUL_DIGIT_W
) (
    input logic          clk,
    input logic          rst_n,
    hts_item_if.sink     item,
    hts_result_if.source result,
    hts_cfg_if.sink      cfg
);

    cmd_t  ctl_cmd;
    stat_t dp_stat;

    // Accept configuration beats at any time
    assign cfg.ready = 1'b1;

    hts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .opcode       (item.opcode),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (dp_stat),
        .cmd          (ctl_cmd)
    );

    hts_datapath #(.DIGIT_W(DIGIT_W)) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl_cmd),
        .stat        (dp_stat),
        .sample_time (item.sample_time),
        .pos_x       (item.pos_x),
        .pos_y       (item.pos_y),
        .pos_z       (item.pos_z),
        .vel_x       (item.vel_x),
        .vel_y       (item.vel_y),
        .vel_z       (item.vel_z),
        .query_time  (item.query_time),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .world_x     (result.world_x),
        .world_y     (result.world_y),
        .world_z     (result.world_z)
    );

    `ASSERT_IMPLY(a_publish_free, ctl_cmd.exec && ctl_cmd.op == OP_PUBLISH, !result.valid || result.ready, "result published over a waiting beat")
    `ASSERT_NEXT(a_publish_valid, ctl_cmd.exec && ctl_cmd.op == OP_PUBLISH, result.valid, "published result not shown")
    `ASSERT_IMPLY(a_mul_busy, dp_stat.mul_done, !item.ready, "product finished while idle")
    `ASSERT_IMPLY(a_load_beat, ctl_cmd.exec && ctl_cmd.op == OP_LOAD, item.valid && item.ready, "sample stored without an item beat")

endmodule

// File: bench/tb_hermite_trajectory_sampler.sv
module tb_hermite_trajectory_sampler;
    import hts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [VEL_W-1:0] vel_t;
    typedef logic signed [129:0]     wide_t;

    typedef struct {
        logic              opcode;
        logic [TIME_W-1:0] sample_time;
        pos_t              pos [3];
        vel_t              vel [3];
        logic [TIME_W-1:0] query_time;
        bit                typed;
        pos_t              want [3];
    } stim_row_t;

    typedef struct {
        pos_t w [3];
    } world_t;

    localparam int    RANDOM_ITEMS = 1600;
    localparam int    DRAIN_CYCLES = 400;
    localparam int    CYCLE_LIMIT  = 3000000;
    localparam pos_t  POS_MAX      = {1'b0, {(POS_W-1){1'b1}}};
    localparam pos_t  POS_MIN      = {1'b1, {(POS_W-1){1'b0}}};
    localparam vel_t  VEL_MAX      = {1'b0, {(VEL_W-1){1'b1}}};
    localparam vel_t  VEL_MIN      = {1'b1, {(VEL_W-1){1'b0}}};

    logic clk;
    logic rst_n;

    hts_item_if   item_bus ();
    hts_result_if res_bus ();
    hts_cfg_if    cfg_bus ();

    hermite_trajectory_sampler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (res_bus),
        .cfg    (cfg_bus)
    );

    // Shadow state of the sampler
    logic [CFG_DATA_W-1:0] sh_row [3];
    pos_t                  sh_origin [3];
    logic [TIME_W-1:0]     sh_old_t, sh_new_t;
    pos_t                  sh_old_p [3], sh_new_p [3];
    vel_t                  sh_old_v [3], sh_new_v [3];
    int                    sh_count;

    world_t    pending_world [$];
    stim_row_t directed [$];
    int        mismatches;
    int        cycles;
    bit        no_idle;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("hermite_trajectory_sampler test failed");
            $finish;
        end
    end

    function automatic pos_t sat48(wide_t v);
        wide_t hi, lo;
        hi = wide_t'(POS_MAX);
        lo = wide_t'(POS_MIN);
        if (v > hi)
            return POS_MAX;
        if (v < lo)
            return POS_MIN;
        return v[POS_W-1:0];
    endfunction

    function automatic world_t frame_map(pos_t loc [3]);
        world_t r;
        wide_t  acc, m, l, o;
        for (int i = 0; i < 3; i++)
        begin
            o = wide_t'(sh_origin[i]);
            acc = o * 130'sd16384;
            for (int j = 0; j < 3; j++)
            begin
                m = wide_t'($signed(sh_row[i][16*j +: 16]));
                l = wide_t'(loc[j]);
                acc = acc + m * l;
            end
            acc = acc + 130'sd8192;
            r.w[i] = sat48(acc >>> 14);
        end
        return r;
    endfunction

    // Advance the shadow store on a beat; return 1 with the world point on evaluate
    function automatic bit predict_beat(stim_row_t s, output world_t r);
        logic [63:0] u, u2, u3, h, q;
        wide_t       h00, h10, h01, h11, hw, acc, t;
        pos_t        loc [3];
        if (s.opcode == OPC_LOAD)
        begin
            if (sh_count == 0)
            begin
                sh_old_t = s.sample_time;
                sh_old_p = s.pos;
                sh_old_v = s.vel;
                sh_count = 1;
            end
            else
            begin
                if (sh_count == 2)
                begin
                    sh_old_t = sh_new_t;
                    sh_old_p = sh_new_p;
                    sh_old_v = sh_new_v;
                end
                sh_new_t = s.sample_time;
                sh_new_p = s.pos;
                sh_new_v = s.vel;
                sh_count = 2;
            end
            return 1'b0;
        end
        if (sh_count == 0)
        begin
            for (int i = 0; i < 3; i++)
                r.w[i] = '0;
            return 1'b1;
        end
        if (sh_count == 1 || sh_new_t <= sh_old_t)
        begin
            r = frame_map(sh_old_p);
            return 1'b1;
        end
        q = 64'(s.query_time);
        h = 64'(sh_new_t - sh_old_t);
        if (q <= 64'(sh_old_t))
            u = '0;
        else if (q >= 64'(sh_new_t))
            u = 64'd65536;
        else
            u = ((q - 64'(sh_old_t)) << 16) / h;
        u2 = (u * u) >> 16;
        u3 = (u2 * u) >> 16;
        h00 = 2 * $signed({66'd0, u3}) - 3 * $signed({66'd0, u2}) + 130'sd65536;
        h10 = $signed({66'd0, u3}) - 2 * $signed({66'd0, u2}) + $signed({66'd0, u});
        h01 = 3 * $signed({66'd0, u2}) - 2 * $signed({66'd0, u3});
        h11 = $signed({66'd0, u3}) - $signed({66'd0, u2});
        hw = $signed({66'd0, h});
        for (int i = 0; i < 3; i++)
        begin
            t = wide_t'(sh_old_p[i]);
            acc = h00 * 130'sd65536 * t;
            t = wide_t'(sh_new_p[i]);
            acc = acc + h01 * 130'sd65536 * t;
            t = wide_t'(sh_old_v[i]);
            acc = acc + h10 * t * hw;
            t = wide_t'(sh_new_v[i]);
            acc = acc + h11 * t * hw;
            acc = acc + 130'sd2147483648;
            loc[i] = sat48(acc >>> 32);
        end
        r = frame_map(loc);
        return 1'b1;
    endfunction

    // Compare each result beat with the oldest expected point
    always @(posedge clk)
    begin
        world_t w;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_world.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h %h %h", res_bus.world_x,
                             res_bus.world_y, res_bus.world_z);
            end
            else
            begin
                w = pending_world.pop_front();
                if (w.w[0] !== res_bus.world_x || w.w[1] !== res_bus.world_y ||
                    w.w[2] !== res_bus.world_z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("world mismatch: want %h %h %h got %h %h %h",
                                 w.w[0], w.w[1], w.w[2], res_bus.world_x,
                                 res_bus.world_y, res_bus.world_z);
                end
            end
        end
    end

    // Result side: stall a random number of cycles per beat
    initial
    begin
        int n;
        res_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 6);
            repeat (n)
            begin
                @(negedge clk);
                res_bus.ready = 1'b0;
            end
            @(negedge clk);
            res_bus.ready = 1'b1;
            do
                @(posedge clk);
            while (!(res_bus.valid && res_bus.ready));
        end
    end

    // Drive one item beat, keeping valid high when there is no gap
    task automatic drive_item(stim_row_t s);
        world_t w;
        int     gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            @(negedge clk);
            item_bus.valid = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        item_bus.opcode      = s.opcode;
        item_bus.sample_time = s.sample_time;
        item_bus.pos_x       = s.pos[0];
        item_bus.pos_y       = s.pos[1];
        item_bus.pos_z       = s.pos[2];
        item_bus.vel_x       = s.vel[0];
        item_bus.vel_y       = s.vel[1];
        item_bus.vel_z       = s.vel[2];
        item_bus.query_time  = s.query_time;
        item_bus.valid       = 1'b1;
        do
            @(posedge clk);
        while (!item_bus.ready);
        if (predict_beat(s, w))
        begin
            if (s.typed)
                w.w = s.want;
            pending_world = {pending_world, w};
        end
    endtask

    // Hold items off until every expected point has come back
    task automatic drain();
        @(negedge clk);
        item_bus.valid = 1'b0;
        wait (pending_world.size() == 0);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        cfg_bus.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == REG_ROW0 || idx == REG_ROW1 || idx == REG_ROW2)
            sh_row[idx] = val;
        else if (idx == REG_ORG_X || idx == REG_ORG_Y || idx == REG_ORG_Z)
            sh_origin[idx - REG_ORG_X] = val;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [15:0] rand_entry();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h4000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic pos_t rand_pos();
        case ($urandom_range(0, 9))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return rand48();
            default: return pos_t'($signed(32'($urandom())) >>> $urandom_range(0, 12));
        endcase
    endfunction

    function automatic vel_t rand_vel();
        case ($urandom_range(0, 7))
            0: return VEL_MAX;
            1: return VEL_MIN;
            2: return $urandom();
            default: return $signed(32'($urandom())) >>> $urandom_range(4, 20);
        endcase
    endfunction

    task automatic add_row(logic op, logic [47:0] st, pos_t px, pos_t py, pos_t pz,
                           vel_t vx, vel_t vy, vel_t vz, logic [47:0] qt,
                           bit typed, pos_t wx, pos_t wy, pos_t wz);
        stim_row_t s;
        s.opcode = op;
        s.sample_time = st;
        s.pos = '{px, py, pz};
        s.vel = '{vx, vy, vz};
        s.query_time = qt;
        s.typed = typed;
        s.want = '{wx, wy, wz};
        directed = {directed, s};
    endtask

    initial
    begin
        stim_row_t        s;
        logic [TIME_W-1:0] last_t, dt;
        logic [47:0]      row;

        rst_n = 1'b0;
        cycles = 0;
        mismatches = 0;
        no_idle = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.opcode = OPC_LOAD;
        item_bus.sample_time = '0;
        item_bus.pos_x = '0;
        item_bus.pos_y = '0;
        item_bus.pos_z = '0;
        item_bus.vel_x = '0;
        item_bus.vel_y = '0;
        item_bus.vel_z = '0;
        item_bus.query_time = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        sh_row = '{ROW0_RST, ROW1_RST, ROW2_RST};
        sh_origin = '{default: '0};
        sh_old_t = '0;
        sh_new_t = '0;
        sh_old_p = '{default: '0};
        sh_new_p = '{default: '0};
        sh_old_v = '{default: '0};
        sh_new_v = '{default: '0};
        sh_count = 0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: empty store, single sample, equal times, clamps, backwards time
        add_row(OPC_EVAL, 48'hffff_ffff_ffff, POS_MAX, POS_MIN, POS_MAX, VEL_MAX, VEL_MIN,
                VEL_MAX, 48'd77, 1, 0, 0, 0);
        add_row(OPC_LOAD, 48'd1000, POS_MAX, POS_MIN, 0, VEL_MAX, VEL_MIN, 0,
                48'hffff_ffff_ffff, 0, 0, 0, 0);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'd5000, 1, POS_MAX, POS_MIN, 0);
        add_row(OPC_LOAD, 48'd1000, 48'sd7, -48'sd9, 48'sd11, 5, -5, 5, 0, 0, 0, 0, 0);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'd1000, 1, POS_MAX, POS_MIN, 0);
        add_row(OPC_LOAD, 48'd66536, 48'sd100, -48'sd200, 48'sd300, VEL_MAX, VEL_MIN,
                -1000, 0, 0, 0, 0, 0);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'd0, 1, 48'sd7, -48'sd9, 48'sd11);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'hffff_ffff_ffff, 1,
                48'sd100, -48'sd200, 48'sd300);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'd1000, 1, 48'sd7, -48'sd9, 48'sd11);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'd66536, 1,
                48'sd100, -48'sd200, 48'sd300);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'd33768, 0, 0, 0, 0);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'd1001, 0, 0, 0, 0);
        add_row(OPC_LOAD, 48'd500, POS_MIN, POS_MAX, POS_MIN, VEL_MIN, VEL_MAX, VEL_MIN,
                0, 0, 0, 0, 0);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'd600, 1, 48'sd100, -48'sd200, 48'sd300);
        add_row(OPC_LOAD, 48'hffff_ffff_ffff, POS_MAX, POS_MAX, POS_MIN, VEL_MAX, VEL_MAX,
                VEL_MIN, 0, 0, 0, 0, 0);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'h8000_0000_0000, 0, 0, 0, 0);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'hffff_ffff_fffe, 0, 0, 0, 0);
        add_row(OPC_LOAD, 48'd0, POS_MIN, POS_MIN, POS_MAX, VEL_MIN, VEL_MIN, VEL_MAX,
                0, 0, 0, 0, 0);
        add_row(OPC_LOAD, 48'hffff_ffff_ffff, POS_MAX, POS_MIN, POS_MAX, VEL_MAX, VEL_MIN,
                VEL_MAX, 0, 0, 0, 0, 0);
        add_row(OPC_EVAL, 0, 0, 0, 0, 0, 0, 0, 48'h7fff_ffff_ffff, 0, 0, 0, 0);
        foreach (directed[k])
            drive_item(directed[k]);

        // Random phases, each under a fresh frame
        last_t = sh_new_t;
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            for (int r = 0; r < 8; r++)
            begin
                if (r < 3)
                begin
                    case (ph)
                        0: row = {3{16'h8000}};
                        1: row = {3{16'h7fff}};
                        7: row = (r == 0) ? ROW0_RST : (r == 1) ? ROW1_RST : ROW2_RST;
                        default: row = {rand_entry(), rand_entry(), rand_entry()};
                    endcase
                end
                else
                begin
                    case (ph)
                        0: row = POS_MIN;
                        1: row = POS_MAX;
                        7: row = '0;
                        default: row = rand_pos();
                    endcase
                end
                write_reg(CFG_IDX_W'(r), row);
            end
            for (int n = 0; n < RANDOM_ITEMS / 8; n++)
            begin
                if (n % 50 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                s.typed = 1'b0;
                s.want = '{default: '0};
                s.pos = '{rand_pos(), rand_pos(), rand_pos()};
                s.vel = '{rand_vel(), rand_vel(), rand_vel()};
                s.query_time = rand48();
                s.sample_time = rand48();
                s.opcode = ($urandom_range(0, 99) < 45) ? OPC_LOAD : OPC_EVAL;
                if (s.opcode == OPC_LOAD)
                begin
                    // Mostly ascending times, sometimes equal, backwards or wild
                    case ($urandom_range(0, 9))
                        0: dt = '0;
                        1: dt = -48'($urandom_range(1, 5000));
                        2: dt = rand48();
                        3, 4: dt = 48'({$urandom(), $urandom()} >> $urandom_range(16, 60));
                        default: dt = 48'($urandom_range(1, 200000));
                    endcase
                    s.sample_time = last_t + dt;
                    last_t = s.sample_time;
                end
                else if ($urandom_range(0, 9) != 0)
                begin
                    dt = sh_new_t - sh_old_t;
                    s.query_time = sh_old_t - (dt >> 3) +
                                   48'(({$urandom(), $urandom()} & 64'hffff_ffff_ffff) %
                                       ({16'd0, dt} + (dt >> 2) + 64'd1));
                end
                drive_item(s);
            end
            no_idle = 1'b0;
        end

        drain();
        if (mismatches == 0)
            $display("hermite_trajectory_sampler test passed");
        else
            $display("hermite_trajectory_sampler test failed");
        $finish;
    end

endmodule
